/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on clk_i, off while rst_ni is low
`define OGT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("order gateway check failed");

// implication form of the above
`define OGT_ASSERT_IMP(lbl, ante, cons) \
  `OGT_ASSERT(lbl, (ante) |-> (cons))

// next-cycle implication form
`define OGT_ASSERT_NXT(lbl, ante, cons) \
  `OGT_ASSERT(lbl, (ante) |=> (cons))

`endif

/* design/ogt_pkg.sv */
// ----------------------------------------------------------------------------
// ogt_pkg
// types and codes shared by the order gateway tracker modules
// ----------------------------------------------------------------------------
package ogt_pkg;

  // transaction kinds
  typedef enum logic [1:0] {
    MODE_ENTER    = 2'd0,
    MODE_ACCEPTED = 2'd1,
    MODE_EXECUTED = 2'd2,
    MODE_REJECTED = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_ZERO_QTY   = 3'd1,
    STATUS_ZERO_PRICE = 3'd2,
    STATUS_RATE       = 3'd3,
    STATUS_FULL       = 3'd4,
    STATUS_UNKNOWN    = 3'd5
  } status_e;

  // tracked order states
  typedef enum logic [2:0] {
    OST_PENDING  = 3'd0,
    OST_ACCEPTED = 3'd1,
    OST_PARTIAL  = 3'd2,
    OST_FILLED   = 3'd3,
    OST_REJECTED = 3'd4
  } ostate_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESP
  } fsm_e;

  // register map index
  localparam logic REG_RATE_LIMIT = 1'b0;
  localparam logic REG_TRACKING   = 1'b1;

  localparam logic [31:0] RATE_LIMIT_RST = 32'd1000;

  // one tracking table entry
  typedef struct packed {
    logic [63:0] token_high;
    logic [47:0] token_low;
    logic [2:0]  ostate;
    logic [31:0] remaining;
    logic [31:0] executed;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic rd_en;
    logic update;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
  } dp_sts_t;

endpackage

/* design/order_gateway_tracker.sv */
// ----------------------------------------------------------------------------
// order_gateway_tracker
// order checks, per-second rate limit and token-keyed order tracking table
// ----------------------------------------------------------------------------
// One input transaction (enter order or response) gives one result
// transaction; both channels use valid/ready.
// Config over an APB-style port: 0x0 order_rate_limit, 0x4 tracking_enabled.
// Write configuration only while the block is idle.
// A transaction that needs the table (passed enter order or any response with
// tracking on) goes through check, table scan, drain, update and result states;
// any other goes from check straight to result. The table scan reads one
// entry per cycle through the single RAM read port.
// One transaction at a time; the next is accepted the cycle after the result
// is taken.
// Reset clears valid bits, counters, the rate window and config to defaults;
// no table clearing pass is needed.
// A stalled receiver holds the result and blocks new input.
// ----------------------------------------------------------------------------
module order_gateway_tracker #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] token_high_i,
  input  logic [47:0] token_low_i,
  input  logic        limit_order_i,
  input  logic [31:0] order_quantity_i,
  input  logic [31:0] order_price_i,
  input  logic [31:0] now_second_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  order_state_o,
  output logic [31:0] remaining_left_o,
  output logic [31:0] executed_total_o,
  output logic [31:0] sent_count_o,
  output logic [31:0] accepted_count_o,
  output logic [31:0] rejected_count_o,
  output logic [31:0] execution_count_o
);
  import ogt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  logic [31:0]   rate_limit_q;
  logic          tracking_q;
  logic          cfg_wr;
  ctrl_cmd_t     cmd;
  dp_sts_t       sts;
  logic [AW-1:0] rd_addr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_limit_q <= RATE_LIMIT_RST;
      tracking_q   <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RATE_LIMIT) rate_limit_q <= pwdata;
      else                            tracking_q   <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_TRACKING) ? {31'd0, tracking_q} : rate_limit_q;

  ogt_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  ogt_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .rd_addr_i         (rd_addr),
    .rate_limit_i      (rate_limit_q),
    .tracking_i        (tracking_q),
    .mode_i            (mode_i),
    .token_high_i      (token_high_i),
    .token_low_i       (token_low_i),
    .limit_order_i     (limit_order_i),
    .order_quantity_i  (order_quantity_i),
    .order_price_i     (order_price_i),
    .now_second_i      (now_second_i),
    .sts_o             (sts),
    .status_o          (status_o),
    .order_state_o     (order_state_o),
    .remaining_left_o  (remaining_left_o),
    .executed_total_o  (executed_total_o),
    .sent_count_o      (sent_count_o),
    .accepted_count_o  (accepted_count_o),
    .rejected_count_o  (rejected_count_o),
    .execution_count_o (execution_count_o)
  );

endmodule

/* design/ogt_ram.sv */
// ----------------------------------------------------------------------------
// ogt_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ogt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ogt_ctrl.sv */
// ----------------------------------------------------------------------------
// ogt_ctrl
// sequencer: accept, check, table scan, update, result handshake
// ----------------------------------------------------------------------------
module ogt_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  ogt_pkg::dp_sts_t                 sts_i,
  output ogt_pkg::ctrl_cmd_t               cmd_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr_o
);
  import ogt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  fsm_e          state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:   state_d = sts_i.need_scan ? ST_SCAN : ST_RESP;
      ST_SCAN:   if (idx_q == LAST_IDX) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESP;
      ST_RESP:   if (out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and scan address
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    idx_d       = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        idx_d      = '0;
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        idx_d       = idx_q + 1'b1;
      end
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_RESP:   out_valid_o = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

  assign rd_addr_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

/* design/ogt_dp.sv */
// ----------------------------------------------------------------------------
// ogt_dp
// datapath: order checks, rate window, counters and tracking table
// ----------------------------------------------------------------------------
module ogt_dp #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ogt_pkg::ctrl_cmd_t               cmd_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr_i,
  input  logic [31:0]                      rate_limit_i,
  input  logic                             tracking_i,
  input  logic [1:0]                       mode_i,
  input  logic [63:0]                      token_high_i,
  input  logic [47:0]                      token_low_i,
  input  logic                             limit_order_i,
  input  logic [31:0]                      order_quantity_i,
  input  logic [31:0]                      order_price_i,
  input  logic [31:0]                      now_second_i,
  output ogt_pkg::dp_sts_t                 sts_o,
  output logic [2:0]                       status_o,
  output logic [2:0]                       order_state_o,
  output logic [31:0]                      remaining_left_o,
  output logic [31:0]                      executed_total_o,
  output logic [31:0]                      sent_count_o,
  output logic [31:0]                      accepted_count_o,
  output logic [31:0]                      rejected_count_o,
  output logic [31:0]                      execution_count_o
);
  import ogt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned EW = $bits(entry_t);

  // latched transaction
  mode_e       mode_q;
  logic [63:0] thi_q;
  logic [47:0] tlo_q;
  logic        lim_q;
  logic [31:0] qty_q, price_q, now_q;

  // rate window and counters
  logic [31:0] win_sec_q, win_ord_q;
  logic [31:0] cnt_sent_q, cnt_acc_q, cnt_rej_q, cnt_exe_q;

  // table bookkeeping
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     rd_vld_q;
  logic [AW-1:0]            rd_idx_q;
  logic                     hit_q, free_q;
  logic [AW-1:0]            hit_idx_q, free_idx_q;
  entry_t                   hit_ent_q;
  entry_t                   rd_ent;
  logic [EW-1:0]            ram_rdata;

  // result
  status_e     status_q;
  ostate_e     ostate_q;
  logic [31:0] rem_q, exe_q;

  // check logic
  logic        is_enter, zero_qty, zero_px, over;
  logic [31:0] win_base, win_inc;

  // update logic
  logic          wr_en;
  logic [AW-1:0] wr_idx;
  entry_t        wr_ent;
  status_e       upd_status;
  logic [31:0]   exe_sum;

  assign is_enter = (mode_q == MODE_ENTER);
  assign zero_qty = (qty_q == '0);
  assign zero_px  = lim_q && (price_q == '0);
  assign win_base = (now_q != win_sec_q) ? '0 : win_ord_q;
  assign win_inc  = (win_base == '1) ? win_base : win_base + 32'd1;
  assign over     = (win_inc > rate_limit_i);

  assign sts_o.need_scan = tracking_i && (!is_enter || (!zero_qty && !zero_px && !over));

  // capture accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_e'(mode_i);
      thi_q   <= token_high_i;
      tlo_q   <= token_low_i;
      lim_q   <= limit_order_i;
      qty_q   <= order_quantity_i;
      price_q <= order_price_i;
      now_q   <= now_second_i;
    end
  end

  // tracking table storage
  ogt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (wr_ent),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);
  assign exe_sum = hit_ent_q.executed + qty_q;

  // table update decision
  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = hit_idx_q;
    wr_ent     = hit_ent_q;
    upd_status = STATUS_OK;
    if (is_enter) begin
      wr_ent.token_high = thi_q;
      wr_ent.token_low  = tlo_q;
      wr_ent.ostate     = OST_PENDING;
      wr_ent.remaining  = qty_q;
      wr_ent.executed   = '0;
      if (hit_q) begin
        wr_en = cmd_i.update;
      end else if (free_q) begin
        wr_en  = cmd_i.update;
        wr_idx = free_idx_q;
      end else begin
        upd_status = STATUS_FULL;
      end
    end else if (!hit_q) begin
      upd_status = STATUS_UNKNOWN;
    end else begin
      wr_en = cmd_i.update;
      case (mode_q)
        MODE_ACCEPTED: wr_ent.ostate = OST_ACCEPTED;
        MODE_EXECUTED: begin
          wr_ent.executed  = exe_sum;
          wr_ent.remaining = (hit_ent_q.remaining > qty_q) ?
                             hit_ent_q.remaining - qty_q : '0;
          wr_ent.ostate    = (hit_ent_q.remaining > qty_q) ? OST_PARTIAL : OST_FILLED;
        end
        default: wr_ent.ostate = OST_REJECTED;
      endcase
    end
  end

  // control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_sec_q  <= '0;
      win_ord_q  <= '0;
      cnt_sent_q <= '0;
      cnt_acc_q  <= '0;
      cnt_rej_q  <= '0;
      cnt_exe_q  <= '0;
      valid_q    <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      // checks, rate window and event counters
      if (cmd_i.eval) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
        if (is_enter) begin
          if (!zero_qty && !zero_px) begin
            win_sec_q <= now_q;
            win_ord_q <= win_inc;
            if (!over) cnt_sent_q <= cnt_sent_q + 32'd1;
          end
        end else begin
          case (mode_q)
            MODE_ACCEPTED: cnt_acc_q <= cnt_acc_q + 32'd1;
            MODE_EXECUTED: cnt_exe_q <= cnt_exe_q + 32'd1;
            default:       cnt_rej_q <= cnt_rej_q + 32'd1;
          endcase
        end
      end
      // scan: lowest matching and lowest free entry
      if (rd_vld_q) begin
        if (valid_q[rd_idx_q] && !hit_q && rd_ent.token_high == thi_q &&
            rd_ent.token_low == tlo_q) begin
          hit_q <= 1'b1;
        end
        if (!valid_q[rd_idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  // scan payload
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_addr_i;
    if (rd_vld_q) begin
      if (valid_q[rd_idx_q] && !hit_q && rd_ent.token_high == thi_q &&
          rd_ent.token_low == tlo_q) begin
        hit_idx_q <= rd_idx_q;
        hit_ent_q <= rd_ent;
      end
      if (!valid_q[rd_idx_q] && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      ostate_q <= OST_PENDING;
      exe_q    <= '0;
      if (is_enter && zero_qty) begin
        status_q <= STATUS_ZERO_QTY;
        rem_q    <= '0;
      end else if (is_enter && zero_px) begin
        status_q <= STATUS_ZERO_PRICE;
        rem_q    <= '0;
      end else if (is_enter && over) begin
        status_q <= STATUS_RATE;
        rem_q    <= '0;
      end else begin
        status_q <= STATUS_OK;
        rem_q    <= is_enter ? qty_q : '0;
      end
    end else if (cmd_i.update) begin
      status_q <= upd_status;
      if (is_enter) begin
        rem_q <= qty_q;
      end else if (hit_q) begin
        ostate_q <= ostate_e'(wr_ent.ostate);
        rem_q    <= wr_ent.remaining;
        exe_q    <= wr_ent.executed;
      end
    end
  end

  assign status_o          = status_q;
  assign order_state_o     = ostate_q;
  assign remaining_left_o  = rem_q;
  assign executed_total_o  = exe_q;
  assign sent_count_o      = cnt_sent_q;
  assign accepted_count_o  = cnt_acc_q;
  assign rejected_count_o  = cnt_rej_q;
  assign execution_count_o = cnt_exe_q;

endmodule

/* design/ogt_checker.sv */
// ----------------------------------------------------------------------------
// ogt_checker
// port-level checks of the order gateway tracker handshakes and results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ogt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [2:0]  order_state_o,
  input logic [31:0] remaining_left_o
);
  import ogt_pkg::*;

  logic refused;

  // result of an order refused by the checks or the rate limit
  assign refused = out_valid_o && (status_o == STATUS_ZERO_QTY ||
                   status_o == STATUS_ZERO_PRICE || status_o == STATUS_RATE);

  // a pending result blocks new input
  `OGT_ASSERT_IMP(a_no_accept_while_pending, out_valid_o, !in_ready_o)

  // a freshly accepted transaction never produces a result in the next cycle
  `OGT_ASSERT_NXT(a_no_instant_result, in_valid_i && in_ready_o, !out_valid_o)

  // a stalled result keeps its status
  `OGT_ASSERT_NXT(a_stall_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o))

  // refused orders report zero remaining quantity and the pending state
  `OGT_ASSERT_IMP(a_refused_zero, refused, remaining_left_o == 32'd0 && order_state_o == OST_PENDING)

endmodule

bind order_gateway_tracker ogt_checker u_ogt_checker (.*);

/* test/tb_order_gateway_tracker.sv */
// ----------------------------------------------------------------------------
// tb_order_gateway_tracker
// self-checking bench for the order gateway tracker
// ----------------------------------------------------------------------------
// Drives enter orders and responses over valid/ready with random gaps and
// stalls. A scoreboard keeps its own copy of the checks, the rate window and
// the tracking table, predicts one result per transaction and compares each
// result in order. Several register settings are run, extremes included.
// ----------------------------------------------------------------------------
module tb_order_gateway_tracker;
  import ogt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned TOKEN_POOL  = 80;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef struct {
    mode_e       mode;
    bit [63:0]   token_high;
    bit [47:0]   token_low;
    bit          limit_order;
    bit [31:0]   quantity;
    bit [31:0]   price;
    bit [31:0]   now_second;
  } order_msg_t;

  typedef struct {
    bit [2:0]  status;
    bit [2:0]  order_state;
    bit [31:0] remaining_left;
    bit [31:0] executed_total;
    bit [31:0] sent_count;
    bit [31:0] accepted_count;
    bit [31:0] rejected_count;
    bit [31:0] execution_count;
  } gateway_result_t;

  // scoreboard: order book copy and queue of predicted results
  class order_book_model;
    bit [31:0]       rate_limit = RATE_LIMIT_RST;
    bit              tracking   = 1'b1;
    bit              slot_used[TABLE_DEPTH];
    bit [111:0]      slot_token[TABLE_DEPTH];
    bit [2:0]        slot_state[TABLE_DEPTH];
    bit [31:0]       slot_remaining[TABLE_DEPTH];
    bit [31:0]       slot_executed[TABLE_DEPTH];
    bit [31:0]       window_sec;
    bit [31:0]       window_cnt;
    bit [31:0]       sent, accepted, rejected, executions;
    gateway_result_t expected_results[$];
    int              mismatches;

    function int find_slot(bit [111:0] tok, bit want_free);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (want_free ? !slot_used[i] : (slot_used[i] && slot_token[i] == tok))
          return i;
      end
      return -1;
    endfunction

    function void note_order(order_msg_t m);
      gateway_result_t r;
      bit [111:0]      tok;
      int              idx;
      r   = '{default: 0};
      tok = {m.token_high, m.token_low};
      if (m.mode == MODE_ENTER) begin
        if (m.quantity == 0) begin
          r.status = STATUS_ZERO_QTY;
        end else if (m.limit_order && m.price == 0) begin
          r.status = STATUS_ZERO_PRICE;
        end else begin
          if (m.now_second != window_sec) begin
            window_sec = m.now_second;
            window_cnt = 0;
          end
          if (window_cnt != '1) window_cnt++;
          if (window_cnt > rate_limit) begin
            r.status = STATUS_RATE;
          end else begin
            sent++;
            r.order_state    = OST_PENDING;
            r.remaining_left = m.quantity;
            if (tracking) begin
              idx = find_slot(tok, 1'b0);
              if (idx < 0) idx = find_slot(tok, 1'b1);
              if (idx < 0) begin
                r.status = STATUS_FULL;
              end else begin
                slot_used[idx]      = 1'b1;
                slot_token[idx]     = tok;
                slot_state[idx]     = OST_PENDING;
                slot_remaining[idx] = m.quantity;
                slot_executed[idx]  = 0;
              end
            end
          end
        end
      end else begin
        case (m.mode)
          MODE_ACCEPTED: accepted++;
          MODE_EXECUTED: executions++;
          default:       rejected++;
        endcase
        if (tracking) begin
          idx = find_slot(tok, 1'b0);
          if (idx < 0) begin
            r.status = STATUS_UNKNOWN;
          end else begin
            case (m.mode)
              MODE_ACCEPTED: slot_state[idx] = OST_ACCEPTED;
              MODE_EXECUTED: begin
                slot_executed[idx] += m.quantity;
                slot_remaining[idx] = (slot_remaining[idx] > m.quantity) ?
                                      slot_remaining[idx] - m.quantity : 0;
                slot_state[idx] = (slot_remaining[idx] == 0) ? OST_FILLED : OST_PARTIAL;
              end
              default:       slot_state[idx] = OST_REJECTED;
            endcase
            r.order_state    = slot_state[idx];
            r.remaining_left = slot_remaining[idx];
            r.executed_total = slot_executed[idx];
          end
        end
      end
      r.sent_count      = sent;
      r.accepted_count  = accepted;
      r.rejected_count  = rejected;
      r.execution_count = executions;
      expected_results.push_back(r);
    endfunction

    function void check_result(gateway_result_t got);
      gateway_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        return;
      end
      want = expected_results.pop_front();
      if (got.status != want.status || got.order_state != want.order_state ||
          got.remaining_left != want.remaining_left ||
          got.executed_total != want.executed_total ||
          got.sent_count != want.sent_count || got.accepted_count != want.accepted_count ||
          got.rejected_count != want.rejected_count ||
          got.execution_count != want.execution_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  mode_i;
  logic [63:0] token_high_i;
  logic [47:0] token_low_i;
  logic        limit_order_i;
  logic [31:0] order_quantity_i, order_price_i, now_second_i;
  logic        out_valid_o, out_ready_i;
  logic [2:0]  status_o, order_state_o;
  logic [31:0] remaining_left_o, executed_total_o;
  logic [31:0] sent_count_o, accepted_count_o, rejected_count_o, execution_count_o;

  order_book_model book = new();
  bit [111:0]      token_pool[TOKEN_POOL];
  bit [31:0]       clock_sec;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              quiet_cycles;

  order_gateway_tracker #(.TABLE_ENTRIES(TABLE_DEPTH)) uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side: check, random stall, watchdog
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      book.check_result('{status_o, order_state_o, remaining_left_o, executed_total_o,
                          sent_count_o, accepted_count_o, rejected_count_o,
                          execution_count_o});
    out_ready_i <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL order_gateway_tracker");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // register write: setup then access phase
  task automatic write_reg(logic idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_RATE_LIMIT) book.rate_limit = data;
    else book.tracking = data[0];
  endtask

  // one input transaction, with an optional random gap in front
  task automatic send_order(order_msg_t m);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= m.mode;
    token_high_i     <= m.token_high;
    token_low_i      <= m.token_low;
    limit_order_i    <= m.limit_order;
    order_quantity_i <= m.quantity;
    order_price_i    <= m.price;
    now_second_i     <= m.now_second;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_order(m);
  endtask

  task automatic send_fixed(mode_e md, bit [111:0] tok, bit lim, bit [31:0] qty,
                            bit [31:0] price);
    send_order('{md, tok[111:48], tok[47:0], lim, qty, price, clock_sec});
  endtask

  // random traffic over a pool larger than the table, so it fills up
  task automatic send_random();
    order_msg_t m;
    bit [111:0] tok;
    if ($urandom_range(19) == 0) clock_sec++;
    if ($urandom_range(199) == 0) clock_sec = $urandom;
    if ($urandom_range(99) < 8) tok = 112'({$urandom, $urandom, $urandom, $urandom});
    else tok = token_pool[$urandom_range(TOKEN_POOL - 1)];
    m.mode        = ($urandom_range(99) < 40) ? MODE_ENTER : mode_e'($urandom_range(1, 3));
    m.token_high  = tok[111:48];
    m.token_low   = tok[47:0];
    m.limit_order = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       m.quantity = 0;
      1:       m.quantity = '1;
      2:       m.quantity = $urandom;
      default: m.quantity = $urandom_range(1, 400);
    endcase
    m.price      = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
    m.now_second = clock_sec;
    send_order(m);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.expected_results.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
  endtask

  initial begin
    bit [31:0] limits[8];
    bit        tracks[8];
    limits           = '{32'd1000, 32'd3, 32'd0, 32'hFFFF_FFFF,
                         32'd2, 32'd1, 32'd5, 32'hFFFF_FFFF};
    tracks           = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid_i       <= 1'b0;
    mode_i           <= MODE_ENTER;
    token_high_i     <= '0;
    token_low_i      <= '0;
    limit_order_i    <= 1'b0;
    order_quantity_i <= '0;
    order_price_i    <= '0;
    now_second_i     <= '0;
    out_ready_i      <= 1'b1;
    quiet_cycles     <= 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    clock_sec        = 0;
    token_pool[0]    = '1;
    token_pool[1]    = '0;
    for (int i = 2; i < TOKEN_POOL; i++)
      token_pool[i] = 112'({$urandom, $urandom, $urandom, $urandom});
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: checks, fills, saturation, unknown tokens, overwrite
    send_fixed(MODE_ENTER, '1, 1'b0, 32'd0, 32'd7);
    send_fixed(MODE_ENTER, '1, 1'b1, 32'd9, 32'd0);
    send_fixed(MODE_ENTER, '1, 1'b0, '1, 32'd0);
    send_fixed(MODE_ENTER, '0, 1'b1, 32'd1, '1);
    send_fixed(MODE_ACCEPTED, '1, 1'b0, 32'd0, 32'd0);
    send_fixed(MODE_EXECUTED, '1, 1'b0, 32'd5, 32'd0);
    send_fixed(MODE_EXECUTED, '1, 1'b0, '1, 32'd0);
    send_fixed(MODE_REJECTED, '0, 1'b0, 32'd0, 32'd0);
    send_fixed(MODE_ACCEPTED, token_pool[5], 1'b0, 32'd1, 32'd1);
    send_fixed(MODE_EXECUTED, token_pool[5], 1'b0, 32'd1, 32'd1);
    send_fixed(MODE_REJECTED, token_pool[5], 1'b0, 32'd1, 32'd1);
    send_fixed(MODE_ENTER, '1, 1'b1, 32'd10, 32'd3);
    send_fixed(MODE_EXECUTED, '1, 1'b0, 32'd4, 32'd0);
    send_fixed(MODE_EXECUTED, '1, 1'b0, 32'd6, 32'd0);
    send_fixed(MODE_ENTER, token_pool[6], 1'b1, 32'h8000_0000, 32'h8000_0000);
    drain();

    // phases: register setting and idle pattern change together
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_RATE_LIMIT, limits[p]);
      write_reg(REG_TRACKING, {31'd0, tracks[p]});
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      repeat (200) send_random();
      drain();
    end

    if (book.mismatches == 0 && book.expected_results.size() == 0)
      $display("PASS order_gateway_tracker");
    else
      $display("FAIL order_gateway_tracker");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/ogt_pkg.sv
design/ogt_ram.sv
design/ogt_ctrl.sv
design/ogt_dp.sv
design/order_gateway_tracker.sv
design/ogt_checker.sv
test/tb_order_gateway_tracker.sv
